/* sv/lru_keyed_value_cache_macros.svh */
// ---------------------------------------------------------------------------
// LRU keyed value cache assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef LRU_KEYED_VALUE_CACHE_MACROS_SVH
`define LRU_KEYED_VALUE_CACHE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every edge outside reset.
`define LKVC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every edge, reset included.
`define LKVC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKVC_ASSERT(lbl, clk, rstn, prop, msg)
`define LKVC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* sv/lkvc_pkg.sv */
// ---------------------------------------------------------------------------
// LRU keyed value cache package
// Shared types and constants of the cache block.
// ---------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned LKVC_CAPACITY = 16;
  localparam int unsigned LKVC_KEY_BITS = 32;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned HANDLE_W = 32;

  // Code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    ACT_GET   = 2'd0,
    ACT_PUT   = 2'd1,
    ACT_CLEAR = 2'd2
  } lkvc_action_e;

  typedef struct packed {
    lkvc_action_e          action;
    logic [KEY_W-1:0]      lookup_key;
    logic [SIZE_W-1:0]     entry_size;
    logic [HANDLE_W-1:0]   entry_handle;
  } lkvc_req_t;

  typedef struct packed {
    logic                  found;
    logic [SIZE_W-1:0]     size_out;
    logic [HANDLE_W-1:0]   handle_out;
    logic                  evicted;
  } lkvc_rsp_t;

  // Lookup outcome handed from the tag array to the data store and top.
  typedef struct packed {
    logic hit;     // key present (get or put)
    logic evict;   // put of a new key into a full store
    logic wr_en;   // put: write value at slot
    logic rd_en;   // get hit: read value at slot
  } lkvc_flags_t;

endpackage

/* sv/lru_keyed_value_cache.sv */
// ---------------------------------------------------------------------------
// LRU keyed value cache
// Fully associative least-recently-used key to (size, handle) cache.
// ---------------------------------------------------------------------------
// The cache takes one request per clock while the output is not stalled and
// returns exactly one response per request, in order. A request is first
// captured in an input register. In the next cycle the tag array compares
// the key against all CAPACITY entries at once; when the output is not
// stalled it also ages the recency ranks and writes the value memory, and
// the result lands in the response register. That compare and rank update
// over the register file sets the rate of one request per cycle. Get
// returns the stored value on a hit and zeros on a miss. Put replaces or
// inserts, and evicts the oldest entry when the store is full. Clear drops
// every entry. Only the low KEY_BITS bits of the key (at most 32) are
// compared. Valid bits are cleared by reset directly, so the cache needs no
// clearing pass after reset.
// ---------------------------------------------------------------------------
`include "lru_keyed_value_cache_macros.svh"

module lru_keyed_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = LKVC_CAPACITY,
  parameter int unsigned KEY_BITS = LKVC_KEY_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  lkvc_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output lkvc_rsp_t rsp_o
);

  localparam int unsigned SW = $clog2(CAPACITY);

  // Input register
  logic      s1_valid_q, s1_valid_d;
  lkvc_req_t s1_req_q;
  logic      s1_adv;

  // Response register (value fields live in the data store)
  logic rsp_valid_q, rsp_valid_d;
  logic found_q, evicted_q;

  lkvc_flags_t   flags;
  logic [SW-1:0] slot;
  logic [SIZE_W-1:0]   size_rd;
  logic [HANDLE_W-1:0] handle_rd;

  // The stage moves when the response register is empty or being drained.
  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_valid_i && req_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (s1_adv) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      s1_req_q <= req_i;
    end
    if (s1_adv) begin
      found_q   <= flags.hit;
      evicted_q <= flags.evict;
    end
  end

  // State is committed only when the request leaves the input register,
  // so the next request always sees the updated tags and ranks.
  lkvc_tag_array #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_tags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .action_i (s1_req_q.action),
    .key_i    (s1_req_q.lookup_key),
    .apply_i  (s1_adv),
    .flags_o  (flags),
    .slot_o   (slot)
  );

  lkvc_data_store #(
    .CAPACITY (CAPACITY)
  ) u_data (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apply_i  (s1_adv),
    .flags_i  (flags),
    .slot_i   (slot),
    .size_i   (s1_req_q.entry_size),
    .handle_i (s1_req_q.entry_handle),
    .size_o   (size_rd),
    .handle_o (handle_rd)
  );

  assign rsp_valid_o      = rsp_valid_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.size_out   = size_rd;
  assign rsp_o.handle_out = handle_rd;
  assign rsp_o.evicted    = evicted_q;

  // Hit and eviction exclude each other.
  `LKVC_ASSERT_NR(a_hit_xor_evict, clk_i,
    rsp_valid_o |-> !(rsp_o.found && rsp_o.evicted), "found and evicted both set")

  // Value fields are zero unless the key was found.
  `LKVC_ASSERT(a_miss_zero, clk_i, rst_ni,
    (rsp_valid_o && !rsp_o.found) |-> ((rsp_o.size_out == '0) && (rsp_o.handle_out == '0)),
    "nonzero value on a miss")

  // A request leaving the input stage always shows up as a response.
  `LKVC_ASSERT(a_adv_rsp, clk_i, rst_ni, s1_adv |=> rsp_valid_q, "response lost")

  // Eviction only for a put that missed.
  `LKVC_ASSERT(a_evict_put, clk_i, rst_ni,
    flags.evict |-> ((s1_req_q.action == ACT_PUT) && !flags.hit), "eviction without put miss")

endmodule

/* sv/lkvc_tag_array.sv */
// ---------------------------------------------------------------------------
// LRU keyed value cache tag array
// Valid bits, keys and recency ranks; parallel lookup and rank update.
// ---------------------------------------------------------------------------
module lkvc_tag_array
  import lkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = LKVC_CAPACITY,
  parameter int unsigned KEY_BITS = LKVC_KEY_BITS,
  localparam int unsigned SW = $clog2(CAPACITY),
  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lkvc_action_e      action_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic              apply_i,
  output lkvc_flags_t       flags_o,
  output logic [SW-1:0]     slot_o
);

  localparam logic [SW-1:0] OLDEST = SW'(CAPACITY - 1);

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [SW-1:0]       rank_q [CAPACITY];
  logic [SW-1:0]       rank_d [CAPACITY];
  logic [KW-1:0]       key_q  [CAPACITY];

  logic [KW-1:0]       key;
  logic [CAPACITY-1:0] hit_vec, free_vec, lru_vec;
  logic                hit, has_free, is_get, is_put, is_clr, fresh, promote;
  logic [SW-1:0]       hit_idx, free_idx, lru_idx, hit_rank;

  // Lowest set bit index.
  function automatic logic [SW-1:0] lowest(input logic [CAPACITY-1:0] vec);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (vec[i]) idx = SW'(i);
    end
    return idx;
  endfunction

  assign key = key_i[KW-1:0];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]  = valid_q[i] && (key_q[i] == key);
      free_vec[i] = !valid_q[i];
      lru_vec[i]  = valid_q[i] && (rank_q[i] == OLDEST);
    end
  end

  assign hit      = |hit_vec;
  assign has_free = |free_vec;
  assign hit_idx  = lowest(hit_vec);
  assign free_idx = lowest(free_vec);
  assign lru_idx  = lowest(lru_vec);
  assign hit_rank = rank_q[hit_idx];

  always_comb begin
    is_get = 1'b0;
    is_put = 1'b0;
    is_clr = 1'b0;
    unique case (action_i)
      ACT_GET:   is_get = 1'b1;
      ACT_PUT:   is_put = 1'b1;
      ACT_CLEAR: is_clr = 1'b1;
      default:   ;
    endcase
  end

  always_comb begin
    if (hit) begin
      slot_o = hit_idx;
    end else if (has_free) begin
      slot_o = free_idx;
    end else begin
      slot_o = lru_idx;
    end
  end

  assign fresh   = is_put && !hit;
  assign promote = (is_get && hit) || is_put;

  assign flags_o.hit   = hit && (is_get || is_put);
  assign flags_o.evict = fresh && !has_free;
  assign flags_o.wr_en = is_put;
  assign flags_o.rd_en = is_get && hit;

  // New entry: every other valid entry ages. Hit: only the younger ones.
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (is_clr) begin
      valid_d = '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_d[i] = '0;
      end
    end else if (promote) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (SW'(i) == slot_o) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (fresh || (rank_q[i] < hit_rank))) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      if (fresh) valid_d[slot_o] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else if (apply_i) begin
      valid_q <= valid_d;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_i && fresh) begin
      key_q[slot_o] <= key;
    end
  end

endmodule

/* sv/lkvc_data_store.sv */
// ---------------------------------------------------------------------------
// LRU keyed value cache data store
// Size and handle memory with registered read; zero unless a get hit.
// ---------------------------------------------------------------------------
module lkvc_data_store
  import lkvc_pkg::*;
#(
  parameter int unsigned CAPACITY = LKVC_CAPACITY,
  localparam int unsigned SW = $clog2(CAPACITY)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                apply_i,
  input  lkvc_flags_t         flags_i,
  input  logic [SW-1:0]       slot_i,
  input  logic [SIZE_W-1:0]   size_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic [SIZE_W-1:0]   size_o,
  output logic [HANDLE_W-1:0] handle_o
);

  logic [SIZE_W+HANDLE_W-1:0] mem [CAPACITY];
  logic [SIZE_W+HANDLE_W-1:0] rd_q;
  logic                       hit_q;

  always_ff @(posedge clk_i) begin
    if (apply_i && flags_i.wr_en) begin
      mem[slot_i] <= {size_i, handle_i};
    end
    if (apply_i && flags_i.rd_en) begin
      rd_q <= mem[slot_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (apply_i) begin
      hit_q <= flags_i.rd_en;
    end
  end

  assign size_o   = hit_q ? rd_q[SIZE_W+HANDLE_W-1:HANDLE_W] : '0;
  assign handle_o = hit_q ? rd_q[HANDLE_W-1:0] : '0;

endmodule
